// ===== hw/rtl/lfpc_pkg.sv =====
`default_nettype none
package lfpc_pkg;

  // scan geometry
  localparam int MaxPoints    = 2048;
  localparam int CntW         = $clog2(MaxPoints);
  localparam int CordicStages = 16;
  localparam int IterW        = $clog2(CordicStages);

  // datapath widths
  localparam int RegW   = 16;
  localparam int TrigW  = 20;
  localparam int ZW     = 34;
  localparam int DistW  = 17;
  localparam int IdxW   = 11;
  localparam int CoeffW = 13;
  localparam int DivCntW = $clog2(CoeffW);
  localparam int NumRegs = 8;
  localparam int RegIdxW = $clog2(NumRegs);

  localparam logic signed [TrigW-1:0] GainQ15  = 20'sd19898;
  localparam logic [CoeffW-1:0]       CoeffOne = 13'd4096;

  typedef enum logic [RegIdxW-1:0] {
    REG_ANGLE_START  = 3'd0,
    REG_ANGLE_STEP   = 3'd1,
    REG_NEAR         = 3'd2,
    REG_FAR          = 3'd3,
    REG_HALF_WIDTH   = 3'd4,
    REG_MIN_INTEN    = 3'd5,
    REG_MIN_RANGE    = 3'd6,
    REG_DEFAULT_DIST = 3'd7
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TRIG,
    ST_MUL_X,
    ST_MUL_Y,
    ST_UPDATE,
    ST_FIN,
    ST_DIV,
    ST_EMIT
  } state_e;

  // arctan(2^-i) with 2^32 units per turn
  function automatic logic [30:0] atan_f(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:    v = 31'd536870912;
      5'd1:    v = 31'd316933406;
      5'd2:    v = 31'd167458907;
      5'd3:    v = 31'd85004756;
      5'd4:    v = 31'd42667331;
      5'd5:    v = 31'd21354465;
      5'd6:    v = 31'd10679838;
      5'd7:    v = 31'd5340245;
      5'd8:    v = 31'd2670163;
      5'd9:    v = 31'd1335087;
      5'd10:   v = 31'd667544;
      5'd11:   v = 31'd333772;
      5'd12:   v = 31'd166886;
      5'd13:   v = 31'd83443;
      5'd14:   v = 31'd41722;
      5'd15:   v = 31'd20861;
      5'd16:   v = 31'd10430;
      5'd17:   v = 31'd5215;
      5'd18:   v = 31'd2608;
      5'd19:   v = 31'd1304;
      5'd20:   v = 31'd652;
      5'd21:   v = 31'd326;
      5'd22:   v = 31'd163;
      5'd23:   v = 31'd81;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/lfpc_cordic.sv =====
`default_nettype none
module lfpc_cordic (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  logic [lfpc_pkg::RegW-1:0]           angle_i,
  output logic                                done_o,
  output logic signed [lfpc_pkg::TrigW-1:0]   cos_o,
  output logic signed [lfpc_pkg::TrigW-1:0]   sin_o
);
  import lfpc_pkg::*;

  logic                     busy_q, busy_d;
  logic                     done_q, done_d;
  logic [IterW-1:0]         iter_q, iter_d;
  logic                     flip_q, flip_d;
  logic signed [TrigW-1:0]  x_q, x_d, y_q, y_d, xs, ys;
  logic signed [ZW-1:0]     z_q, z_d, at;
  logic [RegW-1:0]          a_sum, a_fold;
  logic                     last_iter;

  // fold the angle into the right half plane
  assign a_sum     = angle_i + 16'h4000;
  assign a_fold    = a_sum[RegW-1] ? (angle_i ^ 16'h8000) : angle_i;
  assign xs        = x_q >>> iter_q;
  assign ys        = y_q >>> iter_q;
  assign at        = $signed({{(ZW-31){1'b0}}, atan_f(5'(iter_q))});
  assign last_iter = (iter_q == IterW'(CordicStages - 1));

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    iter_d = iter_q;
    flip_d = flip_q;
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    if (start_i) begin
      busy_d = 1'b1;
      iter_d = '0;
      flip_d = a_sum[RegW-1];
      x_d    = GainQ15;
      y_d    = '0;
      z_d    = ZW'($signed({a_fold, 16'h0000}));
    end else if (busy_q) begin
      if (!z_q[ZW-1]) begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - at;
      end else begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + at;
      end
      iter_d = iter_q + 1'b1;
      if (last_iter) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      iter_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      iter_q <= iter_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flip_q <= flip_d;
    x_q    <= x_d;
    y_q    <= y_d;
    z_q    <= z_d;
  end

  assign done_o = done_q;
  assign cos_o  = flip_q ? -x_q : x_q;
  assign sin_o  = flip_q ? -y_q : y_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lfpc_div.sv =====
`default_nettype none
module lfpc_div (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [lfpc_pkg::RegW-1:0]       num_i,
  input  logic [lfpc_pkg::RegW-1:0]       den_i,
  output logic                            done_o,
  output logic [lfpc_pkg::CoeffW-1:0]     quo_o
);
  import lfpc_pkg::*;

  logic                 busy_q, busy_d;
  logic                 done_q, done_d;
  logic [DivCntW-1:0]   cnt_q, cnt_d;
  logic [RegW:0]        rem_q, rem_d, rem_sub;
  logic [RegW-1:0]      den_q, den_d;
  logic [CoeffW-1:0]    quo_q, quo_d;
  logic                 ge;

  // restoring division, one quotient bit a cycle; num <= den so the
  // quotient needs only CoeffW bits
  assign ge      = (rem_q >= {1'b0, den_q});
  assign rem_sub = ge ? (rem_q - {1'b0, den_q}) : rem_q;

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    den_d  = den_q;
    quo_d  = quo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = {1'b0, num_i};
      den_d  = den_i;
    end else if (busy_q) begin
      quo_d = {quo_q[CoeffW-2:0], ge};
      rem_d = {rem_sub[RegW-1:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DivCntW'(CoeffW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    den_q <= den_d;
    quo_q <= quo_d;
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule
`default_nettype wire

// ===== hw/rtl/lidar_frontal_proximity_coeff.sv =====
`default_nettype none
// frontal proximity coefficient from a stream of lidar points. each input beat is one
// point (range in mm, intensity, tlast on the final point of a scan); its angle is
// angle_start plus index times angle_step, a 16-bit binary angle that wraps. an iterative
// cordic (one micro-rotation a cycle) gives cos/sin in q1.15, one shared multiplier then
// forms x and y in mm, and points inside the frontal window update the running minimum x.
// on the tlast point one beat is sent: coeff (q12, 4096 = clear), nearest x, its index and
// a found flag in tuser; scan state then clears. each point goes through accept,
// CordicStages cordic iterations, the x and y multiplies and the update; the tlast point
// adds a threshold step and, in the linear band, the bit-serial divider, then the output
// register is loaded. s_axis_tready is high only between points; a finished result waits
// in the output register without holding up the next point; a later result then waits
// until it is taken. angle_start and default_distance are sampled at the first point of
// each scan. configuration must be written only while idle; the block does not enforce it.
module lidar_frontal_proximity_coeff (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration write port
  input  logic                              cfg_we_i,
  input  logic [lfpc_pkg::RegIdxW-1:0]      cfg_addr_i,
  input  logic [lfpc_pkg::RegW-1:0]         cfg_data_i,
  // point stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [31:0]                       s_axis_tdata,   // range_mm[15:0], intensity[31:16]
  input  logic                              s_axis_tlast,   // last point of scan
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [47:0]                       m_axis_tdata,   // coeff[12:0], nearest_x[29:13],
                                                            // nearest_index[40:30], zeros
  output logic                              m_axis_tuser    // found
);
  import lfpc_pkg::*;

  // configuration registers
  logic [RegW-1:0] cfg_q [NumRegs];

  // control
  state_e state_q, state_d;
  logic   accept, cordic_start, div_start, emit_fire;
  logic   cordic_done, div_done;

  // per point payload
  logic [RegW-1:0]          range_q, inten_q;
  logic                     last_q;
  logic signed [DistW-1:0]  x_q, y_q;

  // scan state
  logic                     in_scan_q;
  logic [CntW-1:0]          point_cnt_q;
  logic [RegW-1:0]          cur_angle_q;
  logic signed [DistW-1:0]  run_min_q;
  logic [CntW-1:0]          run_idx_q;
  logic                     found_q;
  logic [CoeffW-1:0]        coeff_q;

  // output register
  logic                     m_valid_q;
  logic [47:0]              m_data_q;
  logic                     m_user_q;

  logic [RegW-1:0]          angle_use;
  logic signed [TrigW-1:0]  cos_w, sin_w, mul_b;
  logic signed [DistW:0]    mul_a;
  logic signed [DistW+TrigW:0] prod, prod_rnd, prod_sh;
  logic signed [DistW-1:0]  scaled;
  logic signed [DistW:0]    hw_s, far_s, near_s, y_ext, x_ext, min_ext;
  logic                     qualify, lower, le_near, le_far;
  logic [RegW-1:0]          div_num, div_den;
  logic [CoeffW-1:0]        div_quo;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign angle_use = in_scan_q ? cur_angle_q : cfg_q[REG_ANGLE_START];

  lfpc_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cordic_start),
    .angle_i (angle_use),
    .done_o  (cordic_done),
    .cos_o   (cos_w),
    .sin_o   (sin_w)
  );

  // shared multiplier: x in ST_MUL_X, y in ST_MUL_Y
  assign mul_a    = $signed({2'b00, range_q});
  assign mul_b    = (state_q == ST_MUL_X) ? cos_w : sin_w;
  assign prod     = (DistW+TrigW+1)'(mul_a) * (DistW+TrigW+1)'(mul_b);
  assign prod_rnd = prod + (DistW+TrigW+1)'(16384);
  assign prod_sh  = prod_rnd >>> 15;

  // round to nearest mm, then saturate to the 17-bit range
  always_comb begin
    if (prod_sh > (DistW+TrigW+1)'(65535)) begin
      scaled = 17'sh0FFFF;
    end else if (prod_sh < -(DistW+TrigW+1)'(65536)) begin
      scaled = 17'sh10000;
    end else begin
      scaled = prod_sh[DistW-1:0];
    end
  end

  // frontal window test
  assign hw_s    = $signed({2'b00, cfg_q[REG_HALF_WIDTH]});
  assign far_s   = $signed({2'b00, cfg_q[REG_FAR]});
  assign near_s  = $signed({2'b00, cfg_q[REG_NEAR]});
  assign y_ext   = {y_q[DistW-1], y_q};
  assign x_ext   = {x_q[DistW-1], x_q};
  assign min_ext = {run_min_q[DistW-1], run_min_q};
  assign qualify = (inten_q > cfg_q[REG_MIN_INTEN]) && (range_q > cfg_q[REG_MIN_RANGE])
                && (y_ext < hw_s) && (y_ext > -hw_s) && (x_ext < far_s);
  assign lower   = qualify && (x_q < run_min_q);

  // coefficient band
  assign le_near = (min_ext <= near_s);
  assign le_far  = (min_ext <= far_s);
  assign div_num = run_min_q[RegW-1:0] - cfg_q[REG_NEAR];
  assign div_den = cfg_q[REG_FAR] - cfg_q[REG_NEAR];

  lfpc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quo_o   (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE:   if (accept) state_d = ST_TRIG;
      ST_TRIG:   if (cordic_done) state_d = ST_MUL_X;
      ST_MUL_X:  state_d = ST_MUL_Y;
      ST_MUL_Y:  state_d = ST_UPDATE;
      ST_UPDATE: state_d = last_q ? ST_FIN : ST_IDLE;
      ST_FIN:    state_d = (!le_near && le_far) ? ST_DIV : ST_EMIT;
      ST_DIV:    if (div_done) state_d = ST_EMIT;
      ST_EMIT:   if (emit_fire) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    s_axis_tready = (state_q == ST_IDLE);
    cordic_start  = 1'b0;
    div_start     = 1'b0;
    emit_fire     = 1'b0;
    case (state_q)
      ST_IDLE: cordic_start = accept;
      ST_FIN:  div_start    = !le_near && le_far;
      ST_EMIT: emit_fire    = !m_valid_q || m_axis_tready;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q[REG_ANGLE_START]  <= 16'd0;
      cfg_q[REG_ANGLE_STEP]   <= 16'd182;
      cfg_q[REG_NEAR]         <= 16'd300;
      cfg_q[REG_FAR]          <= 16'd600;
      cfg_q[REG_HALF_WIDTH]   <= 16'd200;
      cfg_q[REG_MIN_INTEN]    <= 16'd10;
      cfg_q[REG_MIN_RANGE]    <= 16'd50;
      cfg_q[REG_DEFAULT_DIST] <= 16'd1000;
    end else if (cfg_we_i) begin
      cfg_q[cfg_addr_i] <= cfg_data_i;
    end
  end

  // point payload and products
  always_ff @(posedge clk_i) begin
    if (accept) begin
      range_q <= s_axis_tdata[15:0];
      inten_q <= s_axis_tdata[31:16];
      last_q  <= s_axis_tlast;
    end
    if (state_q == ST_MUL_X) x_q <= scaled;
    if (state_q == ST_MUL_Y) y_q <= scaled;
    if (state_q == ST_FIN) begin
      coeff_q <= le_near ? '0 : CoeffOne;
    end else if (state_q == ST_DIV && div_done) begin
      coeff_q <= div_quo;
    end
  end

  // scan state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_scan_q   <= 1'b0;
      point_cnt_q <= '0;
      cur_angle_q <= '0;
      run_min_q   <= '0;
      run_idx_q   <= '0;
      found_q     <= 1'b0;
    end else begin
      if (accept) begin
        in_scan_q   <= 1'b1;
        cur_angle_q <= angle_use + cfg_q[REG_ANGLE_STEP];
        if (!in_scan_q) begin
          run_min_q <= $signed({1'b0, cfg_q[REG_DEFAULT_DIST]});
        end
      end
      if (state_q == ST_UPDATE) begin
        point_cnt_q <= (point_cnt_q == CntW'(MaxPoints - 1)) ? '0 : point_cnt_q + 1'b1;
        if (lower) begin
          run_min_q <= x_q;
          run_idx_q <= point_cnt_q;
          found_q   <= 1'b1;
        end
      end
      if (emit_fire) begin
        in_scan_q   <= 1'b0;
        point_cnt_q <= '0;
        run_idx_q   <= '0;
        found_q     <= 1'b0;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (emit_fire) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_fire) begin
      m_data_q <= {7'd0, IdxW'(run_idx_q), run_min_q, coeff_q};
      m_user_q <= found_q;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // the cordic is only launched from idle
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cordic_start |-> (state_q == ST_IDLE))
    else $error("cordic started outside idle");

  // linear band never exceeds one
  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_done |-> (div_quo <= CoeffOne))
    else $error("coefficient above one");

  // without a hit the index stays cleared
  a_idx_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !found_q |-> (run_idx_q == '0))
    else $error("index set without a hit");

  // a sent result closes the scan and raises valid
  a_emit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_fire |=> (m_valid_q && !in_scan_q && (state_q == ST_IDLE)))
    else $error("result beat not presented");

endmodule
`default_nettype wire

// ===== tb/tb_lidar_frontal_proximity_coeff.sv =====
`default_nettype none
module tb_lidar_frontal_proximity_coeff;
  timeunit 1ns;
  timeprecision 1ps;

  import lfpc_pkg::*;

  // arctan(2^-i), 2^32 units per turn, for the bearing predictor
  localparam longint ArcTurn32 [0:23] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861, 10430, 5215,
    2608, 1304, 652, 326, 163, 81
  };
  // worst-case cycles from a tlast beat to its result, plus margin
  localparam int SettleCycles = 64;
  localparam int DrainLimit   = 20000;
  localparam int PhaseBeats   = 110;

  // one result beat, split into its fields
  typedef struct {
    logic [CoeffW-1:0] coeff;
    logic [DistW-1:0]  nearest_x;
    logic [IdxW-1:0]   nearest_index;
    logic              found;
  } proximity_t;

  logic              clk_i         = 1'b0;
  logic              rst_ni        = 1'b0;
  logic              cfg_we_i      = 1'b0;
  logic [RegIdxW-1:0] cfg_addr_i   = '0;
  logic [RegW-1:0]   cfg_data_i    = '0;
  logic              s_axis_tvalid = 1'b0;
  logic              s_axis_tready;
  logic [31:0]       s_axis_tdata  = '0;   // range_mm[15:0], intensity[31:16]
  logic              s_axis_tlast  = 1'b0; // last point of scan
  logic              m_axis_tvalid;
  logic              m_axis_tready = 1'b0;
  logic [47:0]       m_axis_tdata;         // coeff[12:0], nearest_x[29:13],
                                           // nearest_index[40:30], zeros
  logic              m_axis_tuser;         // found

  lidar_frontal_proximity_coeff dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always #4 clk_i = ~clk_i;

  // register shadow (reset values) and the next set to load
  logic [RegW-1:0] reg_shadow [NumRegs] = '{0, 182, 300, 600, 200, 10, 50, 1000};
  logic [RegW-1:0] next_regs  [NumRegs];

  // scan state of the predictor
  logic [CntW-1:0] pt_idx      = '0;
  logic [RegW-1:0] bearing     = '0;
  longint          run_min     = 0;
  logic [IdxW-1:0] run_min_idx = '0;
  bit              hit         = 1'b0;
  bit              scan_open   = 1'b0;

  proximity_t scan_results_q [$];
  int         mismatch_cnt = 0;

  // idling controls; the hold counter is loaded at a rising edge, read at falling edges
  bit tx_idle_on   = 1'b0;
  bit rx_idle_on   = 1'b0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // cos/sin in q1.15 of a 16-bit binary angle; rear half is folded to the front
  function automatic void bearing_trig(input logic [15:0] ang, output longint cos_q,
                                       output longint sin_q);
    logic [15:0] a;
    bit          flip;
    longint      xv, yv, zv, xs, ys;
    int          i;
    a    = ang;
    flip = ang[15] ^ ang[14];
    if (flip) a[15] = ~a[15];
    xv = GainQ15;
    yv = 0;
    zv = longint'($signed(a)) * 65536;
    for (i = 0; i < CordicStages; i++) begin
      xs = xv >>> i;
      ys = yv >>> i;
      if (zv >= 0) begin
        xv = xv - ys;
        yv = yv + xs;
        zv = zv - ArcTurn32[i];
      end else begin
        xv = xv + ys;
        yv = yv - xs;
        zv = zv + ArcTurn32[i];
      end
    end
    cos_q = flip ? -xv : xv;
    sin_q = flip ? -yv : yv;
  endfunction

  // range times q1.15 factor, rounded to nearest mm (ties up), saturated to 17 bits
  function automatic longint to_mm(input logic [15:0] r, input longint t);
    longint v;
    v = (longint'(r) * t + 16384) >>> 15;
    if (v > 65535) v = 65535;
    if (v < -65536) v = -65536;
    return v;
  endfunction

  // advance the scan by one accepted point; on tlast queue the expected result
  task automatic predict_point(input logic [15:0] r, input logic [15:0] inten, input bit last);
    longint     c, s, x, y, near_mm, far_mm, hw, coeff;
    proximity_t res;
    // start angle and default distance are latched at the first point of a scan
    if (!scan_open) begin
      bearing   = reg_shadow[REG_ANGLE_START];
      run_min   = reg_shadow[REG_DEFAULT_DIST];
      scan_open = 1'b1;
    end
    bearing_trig(bearing, c, s);
    x       = to_mm(r, c);
    y       = to_mm(r, s);
    near_mm = reg_shadow[REG_NEAR];
    far_mm  = reg_shadow[REG_FAR];
    hw      = reg_shadow[REG_HALF_WIDTH];
    // strict compare: a tie with the running minimum keeps the older point
    if (inten > reg_shadow[REG_MIN_INTEN] && r > reg_shadow[REG_MIN_RANGE] &&
        y < hw && y > -hw && x < far_mm && x < run_min) begin
      run_min     = x;
      run_min_idx = pt_idx;
      hit         = 1'b1;
    end
    bearing = bearing + reg_shadow[REG_ANGLE_STEP];
    pt_idx  = pt_idx + 1'b1;
    if (last) begin
      if (run_min <= near_mm) coeff = 0;
      else if (run_min <= far_mm) coeff = (run_min - near_mm) * 4096 / (far_mm - near_mm);
      else coeff = CoeffOne;
      res.coeff         = coeff[CoeffW-1:0];
      res.nearest_x     = run_min[DistW-1:0];
      res.nearest_index = run_min_idx;
      res.found         = hit;
      scan_results_q.push_back(res);
      pt_idx      = '0;
      run_min_idx = '0;
      hit         = 1'b0;
      scan_open   = 1'b0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // result checker: compares every accepted beat with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin
    proximity_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (scan_results_q.size() == 0) begin
        $error("result beat with nothing expected: coeff=%0d nearest_x=%0d",
               m_axis_tdata[12:0], $signed(m_axis_tdata[29:13]));
        mismatch_cnt++;
      end else begin
        want = scan_results_q.pop_front();
        if (m_axis_tdata[12:0] !== want.coeff) begin
          $error("coeff: expected %0d, actual %0d", want.coeff, m_axis_tdata[12:0]);
          mismatch_cnt++;
        end
        if (m_axis_tdata[29:13] !== want.nearest_x) begin
          $error("nearest_x: expected %0d, actual %0d", $signed(want.nearest_x),
                 $signed(m_axis_tdata[29:13]));
          mismatch_cnt++;
        end
        if (m_axis_tdata[40:30] !== want.nearest_index) begin
          $error("nearest_index: expected %0d, actual %0d", want.nearest_index,
                 m_axis_tdata[40:30]);
          mismatch_cnt++;
        end
        if (m_axis_tuser !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_axis_tuser);
          mismatch_cnt++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // idling
  // ---------------------------------------------------------------------------

  // mostly no gap, mostly short gaps, now and then a long one
  function automatic int pick_gap(input bit on);
    if (!on || $urandom_range(0, 2) != 0) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(20, 60);
    return $urandom_range(1, 3);
  endfunction

  // receiver: a long hold-off takes priority over the random stalls
  always @(negedge clk_i) begin
    if (rx_hold_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_hold_left--;
    end else if (rx_stall_left > 0) begin
      m_axis_tready <= 1'b0;
      rx_stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      rx_stall_left = pick_gap(rx_idle_on);
    end
  end

  // mode change at a rising edge so the receiver never races it
  task automatic set_idling(input bit tx_on, input bit rx_on);
    @(posedge clk_i);
    tx_idle_on = tx_on;
    rx_idle_on = rx_on;
    @(negedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus helpers, all entered and left at a falling edge
  // ---------------------------------------------------------------------------

  // one point beat; valid stays high into the next call unless a gap is taken
  task automatic send_point(input logic [15:0] r, input logic [15:0] inten, input bit last);
    int gap;
    gap = pick_gap(tx_idle_on);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tdata  <= {inten, r};
    s_axis_tlast  <= last;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predict_point(r, inten, last);
    @(negedge clk_i);
  endtask

  // stop offering and wait for every expected result, then let the block settle
  task automatic drain_scans();
    int waited;
    s_axis_tvalid <= 1'b0;
    waited = 0;
    while (scan_results_q.size() != 0 && waited < DrainLimit) begin
      @(negedge clk_i);
      waited++;
    end
    if (scan_results_q.size() != 0) begin
      $error("%0d expected results never arrived", scan_results_q.size());
      mismatch_cnt++;
      scan_results_q.delete();
    end
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  // write all registers from next_regs, back to back; block must be idle
  task automatic apply_settings();
    for (int i = 0; i < NumRegs; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_addr_i <= reg_idx_e'(i);
      cfg_data_i <= next_regs[i];
      reg_shadow[i] = next_regs[i];
      @(negedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  task automatic load_regs(input logic [15:0] start, input logic [15:0] step,
                           input logic [15:0] near_mm, input logic [15:0] far_mm,
                           input logic [15:0] hw, input logic [15:0] min_inten,
                           input logic [15:0] min_rng, input logic [15:0] dflt);
    next_regs[REG_ANGLE_START]  = start;
    next_regs[REG_ANGLE_STEP]   = step;
    next_regs[REG_NEAR]         = near_mm;
    next_regs[REG_FAR]          = far_mm;
    next_regs[REG_HALF_WIDTH]   = hw;
    next_regs[REG_MIN_INTEN]    = min_inten;
    next_regs[REG_MIN_RANGE]    = min_rng;
    next_regs[REG_DEFAULT_DIST] = dflt;
    apply_settings();
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset register values: thresholds, boundaries and ties
  task automatic test_reset_defaults();
    set_idling(1'b0, 1'b0);
    send_point(16'd1000, 16'd100, 1'b1);     // beyond far: nothing counts
    send_point(16'd400, 16'd100, 1'b0);      // counts at index 0
    send_point(16'd400, 16'd100, 1'b0);      // same x one step over: tie keeps index 0
    send_point(16'd0, 16'hFFFF, 1'b0);       // range too short
    send_point(16'hFFFF, 16'd0, 1'b1);       // intensity too low
    send_point(16'd300, 16'd11, 1'b1);       // exactly at near -> coeff 0
    send_point(16'd599, 16'd11, 1'b1);       // just inside far -> top of band
    send_point(16'd600, 16'd11, 1'b1);       // x equal to far does not count
    send_point(16'd50, 16'd11, 1'b0);        // range at the minimum is rejected
    send_point(16'd51, 16'd10, 1'b0);        // intensity at the minimum is rejected
    send_point(16'd51, 16'd11, 1'b1);        // both just over
    drain_scans();
  endtask

  // register extremes, saturation, negative x, wrap of the angle, inverted band
  task automatic test_register_extremes();
    load_regs(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);    // zero half width: no point fits
    send_point(16'h0000, 16'h0000, 1'b1);
    drain_scans();
    load_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_point(16'hFFFF, 16'hFFFF, 1'b0);    // intensity can never exceed the maximum
    send_point(16'd1, 16'hFFFE, 1'b1);
    drain_scans();
    // quarter turns from straight back: full-scale ranges saturate x both ways
    load_regs(16'h8000, 16'h4000, 16'h0000, 16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000, 16'hFFFF);
    send_point(16'hFFFF, 16'd1, 1'b0);       // behind: most negative x
    send_point(16'hFFFF, 16'd1, 1'b0);
    send_point(16'hFFFF, 16'd1, 1'b0);       // ahead: x clips at the top, not < far
    send_point(16'hFFFF, 16'd1, 1'b1);
    send_point(16'd1234, 16'd1, 1'b0);       // new scan restarts from straight back
    send_point(16'd77, 16'd1, 1'b1);
    drain_scans();
    // far below near, start angle just short of a full turn
    load_regs(16'hFF00, 16'h0080, 16'd2000, 16'd1000, 16'd500, 16'd5, 16'd20, 16'd3000);
    send_point(16'd1500, 16'd9, 1'b0);
    send_point(16'd800, 16'd9, 1'b0);
    send_point(16'd900, 16'd9, 1'b1);        // min under near -> 0
    send_point(16'd1500, 16'd9, 1'b1);       // default above both -> clear
    drain_scans();
  endtask

  // receiver holds off for a long stretch while short scans keep coming
  task automatic test_output_backpressure();
    load_regs(16'hFFC0, 16'd16, 16'd100, 16'd900, 16'd300, 16'd3, 16'd10, 16'd1500);
    set_idling(1'b0, 1'b0);
    @(posedge clk_i);
    rx_hold_left = 400;
    @(negedge clk_i);
    for (int i = 0; i < 14; i++)
      send_point(16'($urandom_range(0, 1200)), 16'($urandom_range(0, 20)), 1'b1);
    drain_scans();                           // sender waits for every result
  endtask

  // random register set; some phases lean on the frontal window, others are wild
  task automatic roll_settings(input int flavor);
    int near_mm;
    next_regs[REG_ANGLE_START] = $urandom_range(0, 1) ? 16'($urandom)
                                                      : 16'(16'hF000 + $urandom_range(0, 16'h1FFF));
    next_regs[REG_ANGLE_STEP]  = ($urandom_range(0, 4) == 0) ? 16'($urandom)
                                                             : 16'($urandom_range(0, 1200));
    near_mm = $urandom_range(0, 1500);
    next_regs[REG_NEAR]         = 16'(near_mm);
    next_regs[REG_FAR]          = 16'(near_mm + $urandom_range(1, 1500));
    next_regs[REG_HALF_WIDTH]   = 16'($urandom_range(0, 1000));
    next_regs[REG_MIN_INTEN]    = 16'($urandom_range(0, 100));
    next_regs[REG_MIN_RANGE]    = 16'($urandom_range(0, 200));
    next_regs[REG_DEFAULT_DIST] = 16'($urandom_range(0, 3000));
    case (flavor)
      1: begin
        next_regs[REG_HALF_WIDTH]   = 16'($urandom);
        next_regs[REG_DEFAULT_DIST] = 16'($urandom);
      end
      2: next_regs[REG_FAR] = 16'($urandom_range(0, near_mm));  // empty linear band
      3: for (int i = 0; i < NumRegs; i++) next_regs[i] = 16'($urandom);
      default: ;
    endcase
    apply_settings();
  endtask

  // well-formed scans with random contents over several register phases
  task automatic test_random_scans();
    int          beats, len, span, ilim;
    logic [15:0] r, inten;
    for (int phase = 0; phase < 12; phase++) begin
      roll_settings(phase % 4);
      set_idling(phase % 3 != 0, phase % 2 != 0);
      span = reg_shadow[REG_FAR] * 2 + 200;
      if (span > 65535) span = 65535;
      ilim = reg_shadow[REG_MIN_INTEN] * 2 + 20;
      if (ilim > 65535) ilim = 65535;
      beats = 0;
      while (beats < PhaseBeats) begin
        case ($urandom_range(0, 19))
          0:       len = $urandom_range(65, 200);
          1, 2, 3, 4, 5: len = $urandom_range(17, 64);
          default: len = $urandom_range(1, 16);
        endcase
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 6) == 0) begin
            r     = 16'($urandom);
            inten = 16'($urandom);
          end else begin
            r     = 16'($urandom_range(0, span));
            inten = 16'($urandom_range(0, ilim));
          end
          send_point(r, inten, k == len - 1);
        end
        beats += len;
        if ($urandom_range(0, 9) == 0) drain_scans();
      end
      drain_scans();
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (4) @(negedge clk_i);
    test_reset_defaults();
    test_register_extremes();
    test_output_backpressure();
    test_random_scans();
    drain_scans();
    if (mismatch_cnt == 0) begin
      $display("lidar_frontal_proximity_coeff regression: pass");
    end else begin
      $display("lidar_frontal_proximity_coeff regression: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #8_000_000;
    $display("lidar_frontal_proximity_coeff regression: fail");
    $finish;
  end

endmodule
`default_nettype wire
